@@ hw/rtl/ifgs_pkg.sv @@
`default_nettype none
package ifgs_pkg;

  // Reciprocal is floor(2^32 / v), so the quotient needs 33 bits.
  localparam int unsigned QuoWidth   = 33;
  localparam int unsigned GradWidth  = 34;
  localparam int unsigned ModelWidth = 2;

  // Lattice model codes.
  localparam logic [ModelWidth-1:0] MODEL_D2Q9 = 2'd0;

  // Neighbor presence flags of one axis.
  typedef struct packed {
    logic first_present;
    logic second_present;
  } ifgs_pres_t;

endpackage
`default_nettype wire

@@ hw/rtl/ifgs_recip.sv @@
`default_nettype none
module ifgs_recip import ifgs_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] den,
  output logic      [QuoWidth-1:0]    quo
);

  // Partial remainder, quotient and divisor at each stage boundary.
  logic [VALUE_WIDTH-1:0] rem_r [QuoWidth+1];
  logic [QuoWidth-1:0]    quo_r [QuoWidth+1];
  logic [VALUE_WIDTH-1:0] div_r [QuoWidth+1];

  // A zero value is read as one.
  assign rem_r[0] = '0;
  assign quo_r[0] = '0;
  assign div_r[0] = (den == '0) ? VALUE_WIDTH'(1) : den;

  // One restoring division step per stage; the dividend 2^32 has only its top bit set.
  for (genvar s = 0; s < QuoWidth; s++) begin : g_step
    logic [VALUE_WIDTH:0] shifted;
    logic                 ge;

    assign shifted = {rem_r[s], (s == 0) ? 1'b1 : 1'b0};
    assign ge      = shifted >= {1'b0, div_r[s]};

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? VALUE_WIDTH'(shifted - {1'b0, div_r[s]}) : shifted[VALUE_WIDTH-1:0];
      quo_r[s+1] <= {quo_r[s][QuoWidth-2:0], ge};
      div_r[s+1] <= div_r[s];
    end
  end

  assign quo = quo_r[QuoWidth];

endmodule
`default_nettype wire

@@ hw/rtl/ifgs_axis.sv @@
`default_nettype none
module ifgs_axis import ifgs_pkg::*; (
  input  wire logic                        clk,
  input  wire logic [QuoWidth-1:0]         rc_center,
  input  wire logic [QuoWidth-1:0]         rc_first,
  input  wire logic [QuoWidth-1:0]         rc_second,
  input  wire ifgs_pres_t                  pres,
  input  wire logic                        bad,
  output logic signed [GradWidth-1:0]      grad
);

  logic signed [GradWidth-1:0] diff;
  logic                        halve;
  logic                        zero;
  logic [QuoWidth-1:0]         op_a;
  logic [QuoWidth-1:0]         op_b;

  // The center stands in for a missing neighbor.
  assign op_a = pres.first_present  ? rc_first  : rc_center;
  assign op_b = pres.second_present ? rc_second : rc_center;

  // Difference stage.
  always_ff @(posedge clk) begin
    diff  <= $signed({1'b0, op_a}) - $signed({1'b0, op_b});
    halve <= pres.first_present & pres.second_present;
    zero  <= bad | ~(pres.first_present | pres.second_present);
  end

  // Halving uses an arithmetic shift, which rounds toward minus infinity.
  always_ff @(posedge clk) begin
    if (zero) begin
      grad <= '0;
    end else if (halve) begin
      grad <= diff >>> 1;
    end else begin
      grad <= diff;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/inverse_field_gradient_stencil_core.sv @@
// Pipeline from start to done: 33 divider stages, difference, halving.
// Throughput: one transaction per cycle; busy is always low, the receiver cannot stall.
// Reset: rst is synchronous, active high; it clears the valid pipeline and sets
// lattice_model to the nine-velocity lattice.
`default_nettype none
module inverse_field_gradient_stencil_core import ifgs_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ModelWidth-1:0]        cfg_data,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [VALUE_WIDTH-1:0]       center_value,
  input  wire logic [VALUE_WIDTH-1:0]       x_first_value,
  input  wire logic                         x_first_present,
  input  wire logic [VALUE_WIDTH-1:0]       x_second_value,
  input  wire logic                         x_second_present,
  input  wire logic [VALUE_WIDTH-1:0]       y_first_value,
  input  wire logic                         y_first_present,
  input  wire logic [VALUE_WIDTH-1:0]       y_second_value,
  input  wire logic                         y_second_present,
  output logic                              done,
  output logic signed [GradWidth-1:0]       grad_x,
  output logic signed [GradWidth-1:0]       grad_y,
  output logic                              model_unsupported
);

  localparam int unsigned Depth = QuoWidth + 2;

  logic [ModelWidth-1:0] lattice_model;
  logic [QuoWidth-1:0]   rc_c, rc_xf, rc_xs, rc_yf, rc_ys;

  logic       vld   [Depth+1];
  logic       badp  [QuoWidth+1];
  ifgs_pres_t presx [QuoWidth+1];
  ifgs_pres_t presy [QuoWidth+1];
  logic       bad_d1, bad_d2;

  assign busy = 1'b0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_model <= MODEL_D2Q9;
    end else if (cfg_we) begin
      lattice_model <= cfg_data;
    end
  end

  // Five reciprocal pipelines, one per value.
  ifgs_recip #(.VALUE_WIDTH(VALUE_WIDTH)) u_rc_c  (.clk, .den(center_value),   .quo(rc_c));
  ifgs_recip #(.VALUE_WIDTH(VALUE_WIDTH)) u_rc_xf (.clk, .den(x_first_value),  .quo(rc_xf));
  ifgs_recip #(.VALUE_WIDTH(VALUE_WIDTH)) u_rc_xs (.clk, .den(x_second_value), .quo(rc_xs));
  ifgs_recip #(.VALUE_WIDTH(VALUE_WIDTH)) u_rc_yf (.clk, .den(y_first_value),  .quo(rc_yf));
  ifgs_recip #(.VALUE_WIDTH(VALUE_WIDTH)) u_rc_ys (.clk, .den(y_second_value), .quo(rc_ys));

  // Valid bits travel alongside the data through the full latency.
  assign vld[0] = start;
  for (genvar s = 0; s < Depth; s++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  // Side information delayed to match the divider pipelines.
  assign badp[0]  = (lattice_model != MODEL_D2Q9);
  assign presx[0] = '{first_present: x_first_present, second_present: x_second_present};
  assign presy[0] = '{first_present: y_first_present, second_present: y_second_present};
  for (genvar s = 0; s < QuoWidth; s++) begin : g_side
    always_ff @(posedge clk) begin
      badp[s+1]  <= badp[s];
      presx[s+1] <= presx[s];
      presy[s+1] <= presy[s];
    end
  end

  always_ff @(posedge clk) begin
    bad_d1 <= badp[QuoWidth];
    bad_d2 <= bad_d1;
  end

  // Per-axis difference and halving.
  ifgs_axis u_axis_x (
    .clk, .rc_center(rc_c), .rc_first(rc_xf), .rc_second(rc_xs),
    .pres(presx[QuoWidth]), .bad(badp[QuoWidth]), .grad(grad_x)
  );
  ifgs_axis u_axis_y (
    .clk, .rc_center(rc_c), .rc_first(rc_yf), .rc_second(rc_ys),
    .pres(presy[QuoWidth]), .bad(badp[QuoWidth]), .grad(grad_y)
  );

  assign done              = vld[Depth];
  assign model_unsupported = bad_d2;

endmodule
`default_nettype wire
